/* rtl/owpc_pkg.sv */
// Package for the obstacle weighted path cost block.
// Holds the payload structs, fixed widths and the sequencer codes.
// Depends on nothing; imported by obstacle_weighted_path_cost.
`timescale 1ns / 1ps

package owpc_pkg;

  // Coordinate and magnitude widths.
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned MAG_W     = COORD_W + 1;
  // Cosine in Q0.16 with one extra bit so that exactly one fits.
  localparam int unsigned COS_BITS  = 16;
  localparam int unsigned COS_W     = COS_BITS + 1;
  localparam int unsigned EXP_TERMS = 16;
  localparam int unsigned COST_W    = 32;
  localparam logic [COS_W-1:0] COS_ONE     = 17'h10000;
  localparam logic [COS_W-1:0] LIMIT_RESET = 17'h08000;

  typedef struct packed {
    logic signed [COORD_W-1:0] robot_x;
    logic signed [COORD_W-1:0] robot_y;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] obstacle_x;
    logic signed [COORD_W-1:0] obstacle_y;
    logic                      obstacle_valid;
    logic                      first_item;
    logic                      last_item;
  } owpc_in_t;

  typedef struct packed {
    logic [COST_W-1:0] path_cost;
    logic              cost_saturated;
  } owpc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_SQRT,
    ST_ABS,
    ST_CMP,
    ST_DIV,
    ST_LIM,
    ST_EDIV,
    ST_EACC,
    ST_RND,
    ST_PEN,
    ST_FIN,
    ST_COST
  } owpc_state_e;

  // What the serial multiplier is computing, and so where its result goes.
  typedef enum logic [2:0] {
    MJ_TSQ1,
    MJ_TSQ2,
    MJ_OSQ1,
    MJ_OSQ2,
    MJ_PROD,
    MJ_DOT1,
    MJ_DOT2,
    MJ_EXP
  } owpc_mjob_e;

endpackage

/* rtl/obstacle_weighted_path_cost.sv */
// Obstacle weighted path cost: top level with its sequencer and shared adder.
// Depends on owpc_pkg for payload structs, widths and sequencer codes.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o / in_data_i) carries one obstacle
//   per transfer, with robot and target positions and first, last and valid
//   marks. The block takes one item at a time; in_ready_o is low while an
//   item is being worked on.
// - Output channel (out_valid_o / out_ready_i / out_data_o) carries one cost
//   per item marked last. The result sits in an output register, so a new
//   item is taken while it waits; a later result waits for it to drain.
// - cfg_we_i / cfg_data_i write the cosine limit.
// - Arithmetic: every arithmetic step runs on one shared 68-bit adder. The
//   bit-serial multiplier takes one multiplier bit per cycle. The square
//   roots and the cosine division work bit by bit, and each of the 16
//   exponential terms is a multiply plus a 33-step division by the term
//   index.
// - Reset clears the sequencer, the penalty sum and the output valid, and
//   loads the limit with its default. No clearing pass is needed.
`timescale 1ns / 1ps

module obstacle_weighted_path_cost
  import owpc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [COS_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  owpc_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output owpc_out_t        out_data_o
);

  // Operand width of the multiplier and width of the shared adder.
  localparam int unsigned OW = MAG_W;
  localparam int unsigned AW = 2 * OW + 2;
  localparam int unsigned PW = 2 * MAG_W;
  localparam int unsigned RW = MAG_W + 2;

  owpc_state_e st_q, st_d;
  owpc_mjob_e  mjob_q, mjob_d;
  logic [5:0]  cnt_q, cnt_d;

  owpc_in_t          item_q;
  logic [MAG_W-1:0]  mag_q [4];
  logic [3:0]        sgn_q;
  logic              diff_we;
  logic [MAG_W-1:0]  diff_mag;

  logic [MAG_W-1:0]  len_t_q, len_t_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [AW-1:0]     acc_q, acc_d, acc_nx;
  logic [AW-1:0]     mpc_q, mpc_d;
  logic [OW-1:0]     mpl_q, mpl_d;
  logic              msub_q, msub_d;
  logic [PW-1:0]     sqn_q, sqn_d;
  logic [MAG_W-1:0]  root_q, root_d;
  logic [RW-1:0]     srem_q, srem_d;
  logic [COS_W-1:0]  cos_q, cos_d;
  logic [32:0]       term_q, term_d;
  logic [3:0]        erem_q, erem_d;
  logic [4:0]        k_q, k_d;
  logic [33:0]       eacc_q, eacc_d;
  logic [COST_W-1:0] pen_q, pen_d;
  logic [COS_W-1:0]  limit_q;

  logic              out_valid_q, out_valid_d;
  owpc_out_t         out_q, out_d;

  // Shared adder-subtractor.
  logic [AW-1:0]     alu_a, alu_b;
  logic              alu_sub;
  logic [AW:0]       alu_sum;
  logic [AW-1:0]     alu_res;
  logic              alu_ge;

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {{AW{1'b0}}, alu_sub};
  assign alu_res = alu_sum[AW-1:0];
  assign alu_ge  = alu_sum[AW];

  logic in_xfer;
  logic out_xfer;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic dot_sub;
  assign dot_sub = (sgn_q[0] ^ sgn_q[2]) != (sgn_q[1] ^ sgn_q[3]);

  // Sequencer: next state and the operands of the shared adder.
  always_comb begin
    st_d        = st_q;
    mjob_d      = mjob_q;
    cnt_d       = cnt_q;
    len_t_d     = len_t_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    acc_nx      = acc_q;
    mpc_d       = mpc_q;
    mpl_d       = mpl_q;
    msub_d      = msub_q;
    sqn_d       = sqn_q;
    root_d      = root_q;
    srem_d      = srem_q;
    cos_d       = cos_q;
    term_d      = term_q;
    erem_d      = erem_q;
    k_d         = k_q;
    eacc_d      = eacc_q;
    pen_d       = pen_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_d       = out_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    diff_we     = 1'b0;
    diff_mag    = '0;

    case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.first_item) begin
            pen_d = '0;
          end
          cnt_d = '0;
          st_d  = ST_DIFF;
        end
      end

      // Four coordinate differences, stored as sign and magnitude.
      ST_DIFF: begin
        case (cnt_q[1:0])
          2'd0: begin
            alu_a = AW'(item_q.target_x);
            alu_b = AW'(item_q.robot_x);
          end
          2'd1: begin
            alu_a = AW'(item_q.target_y);
            alu_b = AW'(item_q.robot_y);
          end
          2'd2: begin
            alu_a = AW'(item_q.obstacle_x);
            alu_b = AW'(item_q.robot_x);
          end
          default: begin
            alu_a = AW'(item_q.obstacle_y);
            alu_b = AW'(item_q.robot_y);
          end
        endcase
        alu_a   = {{(AW-COORD_W){alu_a[COORD_W-1]}}, alu_a[COORD_W-1:0]};
        alu_b   = {{(AW-COORD_W){alu_b[COORD_W-1]}}, alu_b[COORD_W-1:0]};
        alu_sub = 1'b1;
        diff_we = 1'b1;
        diff_mag = alu_res[MAG_W-1] ? (~alu_res[MAG_W-1:0] + MAG_W'(1))
                                    : alu_res[MAG_W-1:0];
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd3) begin
          mpc_d  = AW'(mag_q[0]);
          mpl_d  = mag_q[0];
          acc_d  = '0;
          msub_d = 1'b0;
          mjob_d = MJ_TSQ1;
          st_d   = ST_MUL;
        end
      end

      // Shift-add multiply, one multiplier bit per cycle.
      ST_MUL: begin
        alu_a   = acc_q;
        alu_b   = mpc_q;
        alu_sub = msub_q;
        acc_nx  = mpl_q[0] ? alu_res : acc_q;
        acc_d   = acc_nx;
        mpc_d   = {mpc_q[AW-2:0], 1'b0};
        mpl_d   = {1'b0, mpl_q[OW-1:1]};
        if (mpl_q[OW-1:1] == '0) begin
          case (mjob_q)
            MJ_TSQ1: begin
              mpc_d  = AW'(mag_q[1]);
              mpl_d  = mag_q[1];
              mjob_d = MJ_TSQ2;
            end
            MJ_OSQ1: begin
              mpc_d  = AW'(mag_q[3]);
              mpl_d  = mag_q[3];
              mjob_d = MJ_OSQ2;
            end
            MJ_TSQ2, MJ_OSQ2: begin
              sqn_d  = acc_nx[PW-1:0];
              root_d = '0;
              srem_d = '0;
              cnt_d  = 6'(MAG_W - 1);
              st_d   = ST_SQRT;
            end
            MJ_PROD: begin
              prod_d = acc_nx[PW-1:0];
              if (acc_nx[PW-1:0] == '0) begin
                st_d = ST_FIN;
              end else begin
                mpc_d  = AW'(mag_q[0]);
                mpl_d  = mag_q[2];
                acc_d  = '0;
                msub_d = 1'b0;
                mjob_d = MJ_DOT1;
              end
            end
            MJ_DOT1: begin
              mpc_d  = AW'(mag_q[1]);
              mpl_d  = mag_q[3];
              msub_d = dot_sub;
              mjob_d = MJ_DOT2;
            end
            MJ_DOT2: begin
              st_d = ST_ABS;
            end
            default: begin
              // Next term: floor(term * cos / 65536), then divided by k.
              term_d = acc_nx[COS_BITS+32:COS_BITS];
              erem_d = '0;
              cnt_d  = 6'd32;
              st_d   = ST_EDIV;
            end
          endcase
        end
      end

      // Digit-by-digit square root, one root bit per cycle.
      ST_SQRT: begin
        alu_a   = AW'({srem_q, sqn_q[PW-1:PW-2]});
        alu_b   = AW'({root_q, 2'b01});
        alu_sub = 1'b1;
        srem_d  = alu_ge ? alu_res[RW-1:0] : RW'({srem_q, sqn_q[PW-1:PW-2]});
        root_d  = {root_q[MAG_W-2:0], alu_ge};
        sqn_d   = {sqn_q[PW-3:0], 2'b00};
        cnt_d   = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          if (mjob_q == MJ_TSQ2) begin
            len_t_d = {root_q[MAG_W-2:0], alu_ge};
            if (item_q.obstacle_valid) begin
              mpc_d  = AW'(mag_q[2]);
              mpl_d  = mag_q[2];
              acc_d  = '0;
              msub_d = 1'b0;
              mjob_d = MJ_OSQ1;
              st_d   = ST_MUL;
            end else begin
              st_d = ST_FIN;
            end
          end else begin
            mpc_d  = AW'(len_t_q);
            mpl_d  = {root_q[MAG_W-2:0], alu_ge};
            acc_d  = '0;
            msub_d = 1'b0;
            mjob_d = MJ_PROD;
            st_d   = ST_MUL;
          end
        end
      end

      // Magnitude of the dot product.
      ST_ABS: begin
        alu_a   = '0;
        alu_b   = acc_q;
        alu_sub = 1'b1;
        if (acc_q[AW-1]) begin
          acc_d = alu_res;
        end
        st_d = ST_CMP;
      end

      // A dot product at least the length product clamps the cosine at one.
      ST_CMP: begin
        alu_a   = acc_q;
        alu_b   = AW'(prod_q);
        alu_sub = 1'b1;
        cos_d   = alu_ge ? COS_ONE : '0;
        cnt_d   = 6'(COS_BITS - 1);
        st_d    = alu_ge ? ST_LIM : ST_DIV;
      end

      // Restoring division for the sixteen fraction bits of the cosine.
      ST_DIV: begin
        alu_a   = {acc_q[AW-2:0], 1'b0};
        alu_b   = AW'(prod_q);
        alu_sub = 1'b1;
        acc_d   = alu_ge ? alu_res : {acc_q[AW-2:0], 1'b0};
        cos_d   = {cos_q[COS_W-2:0], alu_ge};
        cnt_d   = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          st_d = ST_LIM;
        end
      end

      // Only obstacles whose cosine is at or below the limit add a penalty.
      ST_LIM: begin
        if (cos_q <= limit_q) begin
          term_d = 33'h1_0000_0000;
          eacc_d = 34'h1_0000_0000;
          k_d    = 5'd1;
          mpc_d  = AW'(33'h1_0000_0000);
          mpl_d  = OW'(cos_q);
          acc_d  = '0;
          msub_d = 1'b0;
          mjob_d = MJ_EXP;
          st_d   = ST_MUL;
        end else begin
          st_d = ST_FIN;
        end
      end

      // Division of the term by its index, one quotient bit per cycle.
      ST_EDIV: begin
        alu_a   = AW'({erem_q, term_q[32]});
        alu_b   = AW'(k_q);
        alu_sub = 1'b1;
        erem_d  = alu_ge ? alu_res[3:0] : {erem_q[2:0], term_q[32]};
        term_d  = {term_q[31:0], alu_ge};
        cnt_d   = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          st_d = ST_EACC;
        end
      end

      // Odd terms subtract, floored at zero; even terms add.
      ST_EACC: begin
        alu_a   = AW'(eacc_q);
        alu_b   = AW'(term_q);
        alu_sub = k_q[0];
        if (k_q[0] && !alu_ge) begin
          eacc_d = '0;
        end else begin
          eacc_d = alu_res[33:0];
        end
        if (k_q == 5'(EXP_TERMS)) begin
          st_d = ST_RND;
        end else begin
          k_d    = k_q + 5'd1;
          mpc_d  = AW'(term_q);
          mpl_d  = OW'(cos_q);
          acc_d  = '0;
          msub_d = 1'b0;
          mjob_d = MJ_EXP;
          st_d   = ST_MUL;
        end
      end

      // Round half up to the output fraction width.
      ST_RND: begin
        alu_a  = AW'(eacc_q);
        alu_b  = AW'(1) << (31 - FRAC_BITS);
        eacc_d = alu_res[33:0];
        st_d   = ST_PEN;
      end

      // Saturating penalty accumulate.
      ST_PEN: begin
        alu_a = AW'(pen_q);
        alu_b = AW'(eacc_q >> (32 - FRAC_BITS));
        pen_d = (alu_res[AW-1:COST_W] != '0) ? '1 : alu_res[COST_W-1:0];
        st_d  = ST_FIN;
      end

      // Distance plus penalty; the cost step follows only for a list that ends here.
      ST_FIN: begin
        alu_a = AW'(len_t_q);
        alu_b = AW'(pen_q);
        acc_d = alu_res;
        st_d  = item_q.last_item ? ST_COST : ST_IDLE;
      end

      // Add one and load the output register once it is free.
      ST_COST: begin
        alu_a = acc_q;
        alu_b = AW'(1) << FRAC_BITS;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.cost_saturated = (alu_res[AW-1:COST_W] != '0);
          out_d.path_cost      = (alu_res[AW-1:COST_W] != '0) ? '1
                                                              : alu_res[COST_W-1:0];
          st_d                 = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mjob_q      <= MJ_TSQ1;
      cnt_q       <= '0;
      pen_q       <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mjob_q      <= mjob_d;
      cnt_q       <= cnt_d;
      pen_q       <= pen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    if (diff_we) begin
      mag_q[cnt_q[1:0]] <= diff_mag;
      sgn_q[cnt_q[1:0]] <= alu_res[MAG_W-1];
    end
    len_t_q <= len_t_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    mpc_q   <= mpc_d;
    mpl_q   <= mpl_d;
    msub_q  <= msub_d;
    sqn_q   <= sqn_d;
    root_q  <= root_d;
    srem_q  <= srem_d;
    cos_q   <= cos_d;
    term_q  <= term_d;
    erem_q  <= erem_d;
    k_q     <= k_d;
    eacc_q  <= eacc_d;
    out_q   <= out_d;
  end

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // The cosine never exceeds one once the limit check is reached.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LIM) |-> (cos_q <= COS_ONE))
    else $error("cosine above one");

  // A clipped cost is all ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.cost_saturated) |-> (&out_data_o.path_cost))
    else $error("saturated cost is not all ones");

  // The penalty only grows, except when a first item clears it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_xfer && in_data_i.first_item) |=> (pen_q >= $past(pen_q)))
    else $error("penalty sum decreased");
`endif

endmodule
